// ----- design/assert_macros.svh -----
// Assertion macros used by the checker of the block pool allocator.
// Depends on nothing; the using module supplies clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is high.
`define FBPA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds through reset.
`define FBPA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- design/fbpa_pkg.sv -----
// Shared types, widths and constants of the fixed block pool allocator.
// Used by every module of the block and by its checker.
package fbpa_pkg;

   // Widths of the item fields and configuration registers
   localparam int unsigned OPCODE_W    = 2;
   localparam int unsigned INDEX_W     = 8;
   localparam int unsigned COUNT_W     = 9;
   localparam int unsigned SIZE_W      = 16;
   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   // Default pool depth and index limit imposed by the 8-bit index field
   localparam int unsigned DEF_NUM_BLOCKS = 256;
   localparam int unsigned INDEX_LIMIT    = 256;

   // Marker for an empty recycle list and the smallest block in bytes
   localparam logic [COUNT_W-1:0] HEAD_EMPTY      = COUNT_W'(256);
   localparam logic [SIZE_W-1:0]  MIN_BLOCK_BYTES = SIZE_W'(4);

   // Register reset values
   localparam logic [COUNT_W-1:0] RST_BLOCK_COUNT = COUNT_W'(256);
   localparam logic [SIZE_W-1:0]  RST_BLOCK_SIZE  = SIZE_W'(4);
   localparam logic [ADDR_W-1:0]  RST_ARENA_BASE  = '0;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SIZE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ARENA_BASE  = 2'd2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INIT  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_POOL_EMPTY = 2'd1,
      ST_BAD_INDEX  = 2'd2,
      ST_POOL_FULL  = 2'd3
   } status_type;

endpackage

// ----- design/fbpa_addr_gen.sv -----
// Byte address of a granted block: arena base plus index times block size.
// Depends on fbpa_pkg for the field widths.
module fbpa_addr_gen (
   input  logic [fbpa_pkg::INDEX_W-1:0] index,
   input  logic [fbpa_pkg::SIZE_W-1:0]  unit_bytes,
   input  logic [fbpa_pkg::ADDR_W-1:0]  arena_base,
   output logic [fbpa_pkg::ADDR_W-1:0]  address
);
   import fbpa_pkg::*;

   logic [SIZE_W-1:0]          bytes;
   logic [INDEX_W+SIZE_W-1:0]  offset;

   // Blocks smaller than a word are laid out as words
   assign bytes  = (unit_bytes < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : unit_bytes;
   assign offset = (INDEX_W+SIZE_W)'(index) * (INDEX_W+SIZE_W)'(bytes);

   // Wraps at 2^32
   assign address = arena_base + ADDR_W'(offset);

endmodule

// ----- design/fixed_block_pool_allocator_top.sv -----
// Response: an accepted request enters S_EXEC; its response is registered when the update commits.
// Pacing: req_stall is high in S_EXEC, so a new item is taken only after the last one has
// committed; the registered link memory read of the recycle head is ready for the update.
// Reset: synchronous, active high; pool of min(256, NUM_BLOCKS) blocks, all free,
// recycle list empty. The link memory is not cleared and needs no clearing pass.
// Depends on fbpa_pkg and fbpa_addr_gen.
module fixed_block_pool_allocator_top #(
   parameter int unsigned NUM_BLOCKS = fbpa_pkg::DEF_NUM_BLOCKS
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [fbpa_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [fbpa_pkg::INDEX_W-1:0]      req_block_index,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fbpa_pkg::STATUS_W-1:0]     rsp_status,
   output logic [fbpa_pkg::INDEX_W-1:0]      rsp_granted_index,
   output logic [fbpa_pkg::ADDR_W-1:0]       rsp_granted_address,
   output logic [fbpa_pkg::COUNT_W-1:0]      rsp_free_count,
   output logic [fbpa_pkg::COUNT_W-1:0]      rsp_used_count,
   // configuration port
   input  logic                              csr_wr_en,
   input  logic [fbpa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fbpa_pkg::*;

   // Only indices below 256 can ever be freed, so the link store stops there
   localparam int unsigned DEPTH = (NUM_BLOCKS < INDEX_LIMIT) ? NUM_BLOCKS : INDEX_LIMIT;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [COUNT_W-1:0] POOL_MAX = COUNT_W'(DEPTH);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   // Control and pool state
   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     head_ff, head_in;
   logic [COUNT_W-1:0]     fresh_ff, fresh_in;
   logic [COUNT_W-1:0]     free_ff, free_in;
   logic [COUNT_W-1:0]     pool_ff, pool_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Configuration registers
   logic [COUNT_W-1:0]     block_count_ff;
   logic [SIZE_W-1:0]      unit_bytes_ff;
   logic [ADDR_W-1:0]      arena_base_ff;

   // Latched request
   opcode_type             op_ff;
   logic [INDEX_W-1:0]     op_index_ff;

   // Response payload
   status_type             status_ff, status_in;
   logic [INDEX_W-1:0]     gidx_ff, gidx_in;
   logic [ADDR_W-1:0]      gaddr_ff;
   logic [COUNT_W-1:0]     rsp_free_ff;
   logic [COUNT_W-1:0]     rsp_used_ff;

   // Link memory
   logic [INDEX_W-1:0]     link_mem [DEPTH];
   logic [INDEX_W-1:0]     link_rd_ff;
   logic                   link_we;

   // Datapath
   logic                   accept;
   logic                   commit;
   logic [COUNT_W:0]       list_sum;
   logic                   rec_nz;
   logic                   rec_gt1;
   logic                   use_recycle;
   logic [INDEX_W-1:0]     alloc_idx;
   logic [ADDR_W-1:0]      alloc_addr;
   logic                   alloc_ok;

   assign req_stall = (state_ff == S_EXEC);
   assign accept    = req_valid && (state_ff == S_IDLE);
   // Update may go ahead once the output register is free or being emptied
   assign commit    = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // Recycle list length is free + fresh - pool; only zero and one matter
   assign list_sum    = {1'b0, free_ff} + {1'b0, fresh_ff};
   assign rec_nz      = (list_sum != {1'b0, pool_ff});
   assign rec_gt1     = rec_nz && (list_sum != ({1'b0, pool_ff} + (COUNT_W+1)'(1)));
   assign use_recycle = rec_nz && (head_ff < POOL_MAX);
   assign alloc_idx   = use_recycle ? head_ff[INDEX_W-1:0] : fresh_ff[INDEX_W-1:0];
   assign alloc_ok    = (op_ff == OP_ALLOC) && (free_ff != '0);

   fbpa_addr_gen u_addr_gen (
      .index      (alloc_idx),
      .unit_bytes (unit_bytes_ff),
      .arena_base (arena_base_ff),
      .address    (alloc_addr)
   );

   // Next state of the pool
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fresh_in     = fresh_ff;
      free_in      = free_ff;
      pool_in      = pool_ff;
      status_in    = ST_OK;
      gidx_in      = '0;
      link_we      = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               case (op_ff)
                  OP_INIT: begin
                     pool_in  = (block_count_ff > POOL_MAX) ? POOL_MAX : block_count_ff;
                     free_in  = pool_in;
                     fresh_in = '0;
                     head_in  = HEAD_EMPTY;
                  end
                  OP_ALLOC: begin
                     if (!alloc_ok) begin
                        status_in = ST_POOL_EMPTY;
                     end else begin
                        gidx_in = alloc_idx;
                        free_in = free_ff - COUNT_W'(1);
                        if (use_recycle) begin
                           head_in = rec_gt1 ? {1'b0, link_rd_ff} : HEAD_EMPTY;
                        end else begin
                           fresh_in = fresh_ff + COUNT_W'(1);
                        end
                     end
                  end
                  OP_FREE: begin
                     if ({1'b0, op_index_ff} >= pool_ff) begin
                        status_in = ST_BAD_INDEX;
                     end else if (free_ff >= pool_ff) begin
                        status_in = ST_POOL_FULL;
                     end else begin
                        link_we = 1'b1;
                        head_in = {1'b0, op_index_ff};
                        free_in = free_ff + COUNT_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= HEAD_EMPTY;
         fresh_ff     <= '0;
         free_ff      <= POOL_MAX;
         pool_ff      <= POOL_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fresh_ff     <= fresh_in;
         free_ff      <= free_in;
         pool_ff      <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= RST_BLOCK_COUNT;
         unit_bytes_ff  <= RST_BLOCK_SIZE;
         arena_base_ff  <= RST_ARENA_BASE;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_BLOCK_SIZE:  unit_bytes_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_ARENA_BASE:  arena_base_ff  <= csr_wdata[ADDR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Request latch
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= opcode_type'(req_opcode);
         op_index_ff <= req_block_index;
      end
   end

   // Link memory: head is read every cycle, so the data is ready in the update cycle
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[op_index_ff[AW-1:0]] <= head_ff[INDEX_W-1:0];
      end
      link_rd_ff <= link_mem[head_ff[AW-1:0]];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (commit) begin
         status_ff   <= status_in;
         gidx_ff     <= gidx_in;
         gaddr_ff    <= (status_in == ST_OK && op_ff == OP_ALLOC) ? alloc_addr : '0;
         rsp_free_ff <= free_in;
         rsp_used_ff <= pool_in - free_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_granted_index   = gidx_ff;
   assign rsp_granted_address = gaddr_ff;
   assign rsp_free_count      = rsp_free_ff;
   assign rsp_used_count      = rsp_used_ff;

endmodule

// ----- design/fbpa_checker.sv -----
// Port-level checks of the block pool allocator, bound to its top level.
// Depends on fbpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbpa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [fbpa_pkg::STATUS_W-1:0]    rsp_status,
   input logic [fbpa_pkg::INDEX_W-1:0]     rsp_granted_index,
   input logic [fbpa_pkg::ADDR_W-1:0]      rsp_granted_address,
   input logic [fbpa_pkg::COUNT_W-1:0]     rsp_free_count,
   input logic [fbpa_pkg::COUNT_W-1:0]     rsp_used_count
);
   import fbpa_pkg::*;

   // A held response stays valid and keeps its status, granted address and free count
   `FBPA_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_granted_address) && $stable(rsp_free_count), "response changed while stalled")

   // Taking an item raises the request stall before the next item can be taken
   `FBPA_ASSERT(a_req_pace, req_valid && !req_stall |=> req_stall, "request taken on consecutive cycles")

   // Only a granted block carries an index and address
   `FBPA_ASSERT(a_grant_zero, rsp_valid && rsp_status != ST_OK |-> rsp_granted_index == '0 && rsp_granted_address == '0, "grant fields set on a failed item")

   // Free plus used never exceeds the largest pool
   `FBPA_ASSERT(a_count_sum, rsp_valid |-> ({1'b0, rsp_free_count} + {1'b0, rsp_used_count}) <= (COUNT_W+1)'(INDEX_LIMIT), "free and used counts inconsistent")

   // Empty pool reports no free blocks, full pool no used blocks
   `FBPA_ASSERT(a_flag_counts, rsp_valid && (rsp_status == ST_POOL_EMPTY || rsp_status == ST_POOL_FULL) |-> (rsp_status == ST_POOL_EMPTY) ? (rsp_free_count == '0) : (rsp_used_count == '0), "status flag disagrees with counts")

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_status          (rsp_status),
   .rsp_granted_index   (rsp_granted_index),
   .rsp_granted_address (rsp_granted_address),
   .rsp_free_count      (rsp_free_count),
   .rsp_used_count      (rsp_used_count)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the fixed block pool allocator: a directed table, then
// random phases at varied register settings; responses checked by table or pool model.
// Depends on fbpa_pkg and fixed_block_pool_allocator_top.
module tb_top;
   import fbpa_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned TOTAL_ITEMS  = 955;
   localparam int unsigned DRAIN_CYCLES = 6;
   // index that no register answers to
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [ADDR_W-1:0]   address;
      logic [COUNT_W-1:0]  free_count;
      logic [COUNT_W-1:0]  used_count;
   } grant_type;

   typedef enum logic [1:0] {STEP_ITEM, STEP_CHECKED, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type          kind;
      logic [OPCODE_W-1:0]    opcode;
      logic [INDEX_W-1:0]     block_index;
      logic [CSR_INDEX_W-1:0] csr_sel;
      logic [CSR_DATA_W-1:0]  csr_value;
      grant_type              grant;
   } step_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [OPCODE_W-1:0]    req_opcode;
   logic [INDEX_W-1:0]     req_block_index;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [INDEX_W-1:0]     rsp_granted_index;
   logic [ADDR_W-1:0]      rsp_granted_address;
   logic [COUNT_W-1:0]     rsp_free_count;
   logic [COUNT_W-1:0]     rsp_used_count;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // pool model state and its copy of the registers
   logic [INDEX_W-1:0] next_link [INDEX_LIMIT];
   logic [COUNT_W-1:0] lifo_head;
   logic [COUNT_W-1:0] fresh_next;
   logic [COUNT_W-1:0] free_left;
   logic [COUNT_W-1:0] pool_size;
   logic [COUNT_W-1:0] cfg_blocks;
   logic [SIZE_W-1:0]  cfg_bytes;
   logic [ADDR_W-1:0]  cfg_base;

   grant_type          awaited_grants[$];
   logic [INDEX_W-1:0] held_blocks[$];
   step_type           directed_plan[$];

   int unsigned errors = 0;
   int unsigned items_sent = 0;
   int unsigned grants_seen = 0;
   int unsigned responses_checked = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_asked = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned run_left = 0;
   int unsigned stall_roll;
   grant_type   seen_grant;

   fixed_block_pool_allocator_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_block_index     (req_block_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_granted_index   (rsp_granted_index),
      .rsp_granted_address (rsp_granted_address),
      .rsp_free_count      (rsp_free_count),
      .rsp_used_count      (rsp_used_count),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- pool model
   function automatic void pool_start();
      pool_size  = (cfg_blocks > COUNT_W'(INDEX_LIMIT)) ? COUNT_W'(INDEX_LIMIT) : cfg_blocks;
      free_left  = pool_size;
      fresh_next = '0;
      lifo_head  = HEAD_EMPTY;
   endfunction

   function automatic void pool_configure(input logic [CSR_INDEX_W-1:0] sel,
                                          input logic [CSR_DATA_W-1:0] value);
      case (sel)
         CSR_BLOCK_COUNT: cfg_blocks = value[COUNT_W-1:0];
         CSR_BLOCK_SIZE:  cfg_bytes  = value[SIZE_W-1:0];
         CSR_ARENA_BASE:  cfg_base   = value[ADDR_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic grant_type pool_predict(input logic [OPCODE_W-1:0] op,
                                              input logic [INDEX_W-1:0] idx);
      grant_type         g;
      int unsigned       recycled;
      logic [SIZE_W-1:0] bytes;
      g = '0;
      g.status = ST_OK;
      case (op)
         OP_INIT: pool_start();
         OP_ALLOC: begin
            if (free_left == 0) begin
               g.status = ST_POOL_EMPTY;
            end else begin
               recycled = free_left + fresh_next - pool_size;
               bytes = (cfg_bytes < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : cfg_bytes;
               // recycled blocks first, LIFO; otherwise the next never-used one
               if (recycled > 0 && lifo_head < HEAD_EMPTY) begin
                  g.index = lifo_head[INDEX_W-1:0];
                  lifo_head = (recycled > 1) ? {1'b0, next_link[g.index]} : HEAD_EMPTY;
               end else begin
                  g.index = fresh_next[INDEX_W-1:0];
                  fresh_next = fresh_next + 1'b1;
               end
               free_left = free_left - 1'b1;
               g.address = cfg_base + ADDR_W'(g.index) * ADDR_W'(bytes);
            end
         end
         OP_FREE: begin
            if ({1'b0, idx} >= pool_size) begin
               g.status = ST_BAD_INDEX;
            end else if (free_left >= pool_size) begin
               g.status = ST_POOL_FULL;
            end else begin
               next_link[idx] = lifo_head[INDEX_W-1:0];
               lifo_head = {1'b0, idx};
               free_left = free_left + 1'b1;
            end
         end
         default: ;
      endcase
      g.free_count = free_left;
      g.used_count = pool_size - free_left;
      return g;
   endfunction

   // ---------------------------------------------------------------- directed table
   task automatic add_item(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx);
      step_type s;
      s = '0;
      s.kind = STEP_ITEM;
      s.opcode = op;
      s.block_index = idx;
      directed_plan.push_back(s);
   endtask

   task automatic add_check(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                            input logic [STATUS_W-1:0] st, input logic [INDEX_W-1:0] gi,
                            input logic [ADDR_W-1:0] ga, input logic [COUNT_W-1:0] fc,
                            input logic [COUNT_W-1:0] uc);
      step_type s;
      s = '0;
      s.kind = STEP_CHECKED;
      s.opcode = op;
      s.block_index = idx;
      s.grant = '{st, gi, ga, fc, uc};
      directed_plan.push_back(s);
   endtask

   task automatic add_csr(input logic [CSR_INDEX_W-1:0] sel, input logic [CSR_DATA_W-1:0] v);
      step_type s;
      s = '0;
      s.kind = STEP_CSR;
      s.csr_sel = sel;
      s.csr_value = v;
      directed_plan.push_back(s);
   endtask

   // ---------------------------------------------------------------- drivers
   function automatic int pick_gap(input bit quiet);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // offer one item, predict it once accepted, then, if a gap is asked for, drop valid and idle through it
   task automatic offer_item(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                             input int gap, input bit typed, input grant_type typed_grant);
      grant_type g;
      int        k;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_block_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      g = pool_predict(op, idx);
      awaited_grants.push_back(typed ? typed_grant : g);
      items_sent++;
      // keep the list of blocks the sender believes it holds
      if (g.status == ST_OK) begin
         case (op)
            OP_ALLOC: begin
               held_blocks.push_back(g.index);
               grants_seen++;
            end
            OP_FREE: begin
               for (k = 0; k < held_blocks.size(); k++) begin
                  if (held_blocks[k] == idx) begin
                     held_blocks.delete(k);
                     break;
                  end
               end
            end
            OP_INIT: held_blocks.delete();
            default: ;
         endcase
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] sel,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      pool_configure(sel, value);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------- response stall
   // Random stretches of stall and no stall, plus a long hold-off when asked.
   always @(posedge clock) begin
      if (hold_asked != hold_seen) begin
         hold_seen = hold_asked;
         hold_left = $urandom_range(60, 120);
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         run_left = 0;
         rsp_stall <= 1'b1;
      end else if (run_left > 0) begin
         run_left = run_left - 1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 40) begin
            rsp_stall <= 1'b0;
            run_left = $urandom_range(0, 29);
         end else if (stall_roll < 85) begin
            rsp_stall <= 1'b1;
            run_left = $urandom_range(0, 2);
         end else if (stall_roll < 95) begin
            rsp_stall <= 1'b0;
            run_left = $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            run_left = $urandom_range(7, 39);
         end
      end
   end

   // ---------------------------------------------------------------- response check
   task automatic note_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_grants.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, status %0d index %0d", $time, rsp_status,
                     rsp_granted_index);
         end else begin
            seen_grant = awaited_grants.pop_front();
            responses_checked++;
            if (rsp_status !== seen_grant.status)
               note_mismatch("status", seen_grant.status, rsp_status);
            if (rsp_granted_index !== seen_grant.index)
               note_mismatch("granted_index", seen_grant.index, rsp_granted_index);
            if (rsp_granted_address !== seen_grant.address)
               note_mismatch("granted_address", seen_grant.address, rsp_granted_address);
            if (rsp_free_count !== seen_grant.free_count)
               note_mismatch("free_count", seen_grant.free_count, rsp_free_count);
            if (rsp_used_count !== seen_grant.used_count)
               note_mismatch("used_count", seen_grant.used_count, rsp_used_count);
         end
      end
   end

   // ---------------------------------------------------------------- run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run limit reached, %0d responses outstanding", $time,
                  awaited_grants.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main sequence
   initial begin
      int unsigned        r;
      int unsigned        k;
      int unsigned        phase;
      int unsigned        span;
      int unsigned        alloc_bias;
      bit                 quiet;
      logic [OPCODE_W-1:0] op;
      logic [INDEX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] value;

      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_NOP;
      req_block_index = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_BLOCK_COUNT;
      csr_wdata = '0;
      cfg_blocks = RST_BLOCK_COUNT;
      cfg_bytes = RST_BLOCK_SIZE;
      cfg_base = RST_ARENA_BASE;
      pool_start();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // fresh pool after reset: no-op, full-pool free, fresh grants
      add_check(OP_NOP,   8'hFF, ST_OK,        8'd0, 32'd0, 9'd256, 9'd0);
      add_check(OP_FREE,  8'h00, ST_POOL_FULL, 8'd0, 32'd0, 9'd256, 9'd0);
      add_check(OP_ALLOC, 8'h00, ST_OK,        8'd0, 32'd0, 9'd255, 9'd1);
      add_check(OP_ALLOC, 8'h00, ST_OK,        8'd1, 32'd4, 9'd254, 9'd2);
      // recycling, LIFO order, and an undetected double free
      add_item(OP_FREE, 8'hFF);
      add_item(OP_ALLOC, 8'h00);
      add_item(OP_FREE, 8'h01);
      add_item(OP_FREE, 8'h01);
      add_item(OP_ALLOC, 8'h00);
      add_item(OP_ALLOC, 8'h00);
      add_item(OP_ALLOC, 8'h00);
      add_check(OP_INIT,  8'h00, ST_OK,        8'd0, 32'd0, 9'd256, 9'd0);
      // pool size only takes effect at the next init
      add_csr(CSR_BLOCK_COUNT, 32'd1);
      add_check(OP_FREE,  8'h00, ST_POOL_FULL, 8'd0, 32'd0, 9'd256, 9'd0);
      add_check(OP_INIT,  8'h00, ST_OK,        8'd0, 32'd0, 9'd1,   9'd0);
      add_check(OP_ALLOC, 8'h00, ST_OK,        8'd0, 32'd0, 9'd0,   9'd1);
      add_check(OP_ALLOC, 8'h00, ST_POOL_EMPTY, 8'd0, 32'd0, 9'd0,  9'd1);
      add_check(OP_FREE,  8'h01, ST_BAD_INDEX, 8'd0, 32'd0, 9'd0,   9'd1);
      // tiny block size, top base, a write to the unused index
      add_csr(CSR_BLOCK_SIZE, 32'd0);
      add_csr(CSR_ARENA_BASE, 32'hFFFF_FFFF);
      add_csr(CSR_SPARE, 32'h5A5A_A5A5);
      add_item(OP_FREE, 8'h00);
      add_check(OP_ALLOC, 8'h00, ST_OK, 8'd0, 32'hFFFF_FFFF, 9'd0, 9'd1);
      // empty pool
      add_csr(CSR_BLOCK_COUNT, 32'd0);
      add_check(OP_INIT,  8'h00, ST_OK,         8'd0, 32'd0, 9'd0, 9'd0);
      add_check(OP_ALLOC, 8'h00, ST_POOL_EMPTY, 8'd0, 32'd0, 9'd0, 9'd0);
      add_check(OP_FREE,  8'hFF, ST_BAD_INDEX,  8'd0, 32'd0, 9'd0, 9'd0);
      // oversized pool count saturates; largest block wraps the address
      add_csr(CSR_BLOCK_COUNT, 32'h1FF);
      add_csr(CSR_BLOCK_SIZE, 32'hFFFF);
      add_check(OP_INIT,  8'h00, ST_OK, 8'd0, 32'd0,         9'd256, 9'd0);
      add_check(OP_ALLOC, 8'h00, ST_OK, 8'd0, 32'hFFFF_FFFF, 9'd255, 9'd1);
      add_check(OP_ALLOC, 8'h00, ST_OK, 8'd1, 32'h0000_FFFE, 9'd254, 9'd2);

      foreach (directed_plan[n]) begin
         if (directed_plan[n].kind == STEP_CSR) begin
            drain_results();
            csr_write(directed_plan[n].csr_sel, directed_plan[n].csr_value);
         end else begin
            offer_item(directed_plan[n].opcode, directed_plan[n].block_index, pick_gap(1'b0),
                       directed_plan[n].kind == STEP_CHECKED, directed_plan[n].grant);
         end
      end

      // random phases, each under its own register setting
      phase = 0;
      while (items_sent < TOTAL_ITEMS) begin
         drain_results();
         r = $urandom_range(0, 99);
         if (r < 5)       value = 0;
         else if (r < 15) value = 1;
         else if (r < 25) value = 2;
         else if (r < 60) value = $urandom_range(3, 16);
         else if (r < 75) value = $urandom_range(17, 255);
         else if (r < 88) value = 256;
         else             value = $urandom_range(257, 511);
         csr_write(CSR_BLOCK_COUNT, value);
         if ($urandom_range(0, 99) < 70) begin
            r = $urandom_range(0, 99);
            if (r < 15)      value = $urandom_range(0, 3);
            else if (r < 35) value = 4;
            else if (r < 50) value = 16'hFFFF;
            else             value = $urandom_range(5, 65534);
            csr_write(CSR_BLOCK_SIZE, value);
         end
         if ($urandom_range(0, 99) < 70) begin
            r = $urandom_range(0, 99);
            if (r < 20)      value = 0;
            else if (r < 35) value = 32'hFFFF_FFFF;
            else             value = $urandom;
            csr_write(CSR_ARENA_BASE, value);
         end

         quiet = ($urandom_range(0, 3) == 0) || (phase == 2);
         r = $urandom_range(0, 3);
         alloc_bias = (r == 0) ? 30 : (r == 1) ? 50 : (r == 2) ? 70 : 90;
         span = $urandom_range(40, 120);
         // long receiver hold-off while items keep coming back to back
         if (phase == 2) hold_asked++;
         if ($urandom_range(0, 99) < 85)
            offer_item(OP_INIT, INDEX_W'($urandom), pick_gap(quiet), 1'b0, '0);

         repeat (span) begin
            r = $urandom_range(0, 99);
            idx = INDEX_W'($urandom);
            if (r < 3) begin
               op = OP_NOP;
            end else if (r < 5) begin
               op = OP_INIT;
            end else if (r < 12) begin
               // stray frees: bad index, full pool, double free
               op = OP_FREE;
               if (pool_size > 0 && $urandom_range(0, 1) == 1)
                  idx = INDEX_W'($urandom_range(0, pool_size - 1));
            end else if (held_blocks.size() > 0 && $urandom_range(0, 99) >= alloc_bias) begin
               op = OP_FREE;
               k = $urandom_range(0, held_blocks.size() - 1);
               idx = held_blocks[k];
            end else begin
               op = OP_ALLOC;
            end
            if ($urandom_range(0, 299) == 0) hold_asked++;
            offer_item(op, idx, pick_gap(quiet), 1'b0, '0);
            // now and then the sender waits for every response
            if ($urandom_range(0, 199) == 0) drain_results();
         end
         phase++;
      end

      drain_results();
      $display("Ran %0d items (%0d random phases): %0d blocks granted, %0d responses checked,",
               items_sent, phase, grants_seen, responses_checked);
      $display("with %0d field mismatches.", errors);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
